// File: rtl/core/ppcl_pkg.sv
`default_nettype none

package ppcl_pkg;

    // Field widths of the request, result and configuration transfers.
    localparam int unsigned OFF_W    = 40;
    localparam int unsigned WITHIN_W = 12;
    localparam int unsigned LEFT_W   = 13;
    localparam int unsigned PAGE_W   = OFF_W - WITHIN_W;
    localparam int unsigned PIN_W    = 16;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned STATUS_W = 3;

    // Chunk size in bytes; chunks start on multiples of it.
    localparam logic [LEFT_W-1:0] CHUNK_BYTES = LEFT_W'(2 ** WITHIN_W);

    // Pin counts saturate here.
    localparam logic [PIN_W-1:0] PIN_MAX = '1;

    // Default number of cache entries.
    localparam int unsigned POOL_ENTRIES_DEF = 8;

    // Request type codes.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_BEYOND     = 3'd2,
        ST_ALL_PINNED = 3'd3,
        ST_UNDERFLOW  = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REL_RD,
        S_SCAN,
        S_FIN
    } t_state;

    // Kind of result that the commit state produces.
    typedef enum logic [1:0] {
        FIN_BEYOND,
        FIN_REL_OOR,
        FIN_REL,
        FIN_ACQ
    } t_fin;

endpackage

`default_nettype wire

// File: rtl/core/ppcl_ram.sv
`default_nettype none

module ppcl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                                i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/pinned_page_cache_lookup.sv
// Fully associative cache directory for 4096-byte chunks of a file, with a pin
// count per entry. An acquire either pins the entry that holds the page, or
// refills the first invalid or unpinned entry at or after the round-robin
// pointer and reports the evicted page, or reports that all entries are
// pinned; a release removes one pin from a slot. Page tags and pin counts sit
// in two memories with one write port and one read port each, which one
// sequencer walks one entry per cycle, so the block takes one request at a
// time. After an acquire transfer the input stays stalled through the check
// state, the scan (which ends early when the page hits) and the commit state.
// A release stalls it through the read state and the commit state, an offset
// at or beyond the file end through the check and commit states. The commit
// state also waits while the previous result is still stalled in the output
// register. A finished result waits in the output register while the next
// request is taken. The file size register may be written whenever the block
// is idle; its port is always ready.
`default_nettype none

module pinned_page_cache_lookup #(
    parameter int unsigned POOL_ENTRIES = ppcl_pkg::POOL_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppcl_pkg::OFF_W-1:0]      i_cfg_file_bytes,
    // Request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [ppcl_pkg::OFF_W-1:0]      i_byte_offset,
    input  logic [ppcl_pkg::SLOT_W-1:0]     i_release_slot,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ppcl_pkg::STATUS_W-1:0]   o_status,
    output logic [ppcl_pkg::SLOT_W-1:0]     o_slot,
    output logic [ppcl_pkg::OFF_W-1:0]      o_page_base,
    output logic [ppcl_pkg::WITHIN_W-1:0]   o_within_offset,
    output logic [ppcl_pkg::LEFT_W-1:0]     o_bytes_left,
    output logic                            o_evicted_valid,
    output logic [ppcl_pkg::OFF_W-1:0]      o_evicted_base,
    output logic [ppcl_pkg::PIN_W-1:0]      o_pin_count
);

    localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int unsigned SW = ppcl_pkg::SLOT_W;
    localparam int unsigned OW = ppcl_pkg::OFF_W;
    localparam int unsigned WW = ppcl_pkg::WITHIN_W;
    localparam int unsigned LW = ppcl_pkg::LEFT_W;
    localparam int unsigned PW = ppcl_pkg::PAGE_W;
    localparam int unsigned NW = ppcl_pkg::PIN_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);

    // Control state.
    ppcl_pkg::t_state       r_state, n_state;
    ppcl_pkg::t_fin         r_fin, n_fin;
    logic [OW-1:0]          r_file_bytes;
    logic [POOL_ENTRIES-1:0] r_valid, n_valid;
    logic [IW-1:0]          r_vp, n_vp;
    logic                   r_out_valid, n_out_valid;

    // Request and scan working registers.
    logic [OW-1:0]          r_offset, n_offset;
    logic [SW-1:0]          r_rel_slot, n_rel_slot;
    logic [LW-1:0]          r_len, n_len;
    logic [IW-1:0]          r_cur, n_cur;
    logic [IW-1:0]          r_cnt, n_cnt;
    logic                   r_hit, n_hit;
    logic [IW-1:0]          r_idx, n_idx;
    logic [NW-1:0]          r_pins, n_pins;
    logic [PW-1:0]          r_pg, n_pg;
    logic                   r_vld, n_vld;
    logic                   r_cand_found, n_cand_found;
    logic [IW-1:0]          r_cand, n_cand;
    logic                   r_ev_valid, n_ev_valid;
    logic [PW-1:0]          r_ev_page, n_ev_page;

    // Result register.
    ppcl_pkg::t_status      r_status, n_status;
    logic [SW-1:0]          r_slot, n_slot;
    logic [OW-1:0]          r_page_base, n_page_base;
    logic [WW-1:0]          r_within, n_within;
    logic [LW-1:0]          r_left, n_left;
    logic                   r_evicted_valid, n_evicted_valid;
    logic [OW-1:0]          r_evicted_base, n_evicted_base;
    logic [NW-1:0]          r_pin_count, n_pin_count;

    // Memory ports.
    logic [IW-1:0]          ram_raddr;
    logic [PW-1:0]          rd_page;
    logic [NW-1:0]          rd_pins;
    logic                   page_we;
    logic                   pins_we;
    logic [IW-1:0]          pins_waddr;
    logic [NW-1:0]          pins_wdata;

    // Decoded request and scan conditions.
    logic [PW-1:0]          req_page;
    logic [WW-1:0]          req_within;
    logic [OW-1:0]          req_base;
    logic [OW-1:0]          span;
    logic [IW-1:0]          nxt_cur;
    logic                   cur_valid;
    logic                   scan_hit;
    logic                   scan_free;
    logic                   out_free;
    logic                   fin_go;
    logic                   fill_go;
    logic [NW-1:0]          hit_pins;

    assign req_page   = r_offset[OW-1:WW];
    assign req_within = r_offset[WW-1:0];
    assign req_base   = {req_page, {WW{1'b0}}};
    assign span       = r_file_bytes - req_base;
    assign nxt_cur    = (r_cur == LAST_IDX) ? '0 : r_cur + IW'(1);
    assign cur_valid  = r_valid[r_cur];
    assign scan_hit   = cur_valid && (rd_page == req_page);
    assign scan_free  = !cur_valid || (rd_pins == '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fin_go     = (r_state == ppcl_pkg::S_FIN) && out_free;
    assign fill_go    = fin_go && (r_fin == ppcl_pkg::FIN_ACQ) && !r_hit && r_cand_found;
    assign hit_pins   = (r_pins == ppcl_pkg::PIN_MAX) ? ppcl_pkg::PIN_MAX : r_pins + NW'(1);

    // Page tag and pin count stores, one entry per slot.
    ppcl_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_ENTRIES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (r_cand),
        .i_wdata (req_page),
        .i_raddr (ram_raddr),
        .o_rdata (rd_page)
    );

    ppcl_ram #(
        .WIDTH (NW),
        .DEPTH (POOL_ENTRIES)
    ) u_pins_ram (
        .i_clk   (i_clk),
        .i_we    (pins_we),
        .i_waddr (pins_waddr),
        .i_wdata (pins_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_pins)
    );

    // Read address: the released slot at transfer, the round-robin pointer in the check state, then the scan walk.
    always_comb begin
        unique case (r_state)
            ppcl_pkg::S_IDLE:  ram_raddr = IW'(i_release_slot);
            ppcl_pkg::S_CHECK: ram_raddr = r_vp;
            ppcl_pkg::S_SCAN:  ram_raddr = nxt_cur;
            default:           ram_raddr = r_cur;
        endcase
    end

    // Sequencer: next state, working registers, result and memory writes.
    always_comb begin
        n_state         = r_state;
        n_fin           = r_fin;
        n_valid         = r_valid;
        n_vp            = r_vp;
        n_out_valid     = r_out_valid && i_out_stall;
        n_offset        = r_offset;
        n_rel_slot      = r_rel_slot;
        n_len           = r_len;
        n_cur           = r_cur;
        n_cnt           = r_cnt;
        n_hit           = r_hit;
        n_idx           = r_idx;
        n_pins          = r_pins;
        n_pg            = r_pg;
        n_vld           = r_vld;
        n_cand_found    = r_cand_found;
        n_cand          = r_cand;
        n_ev_valid      = r_ev_valid;
        n_ev_page       = r_ev_page;
        n_status        = r_status;
        n_slot          = r_slot;
        n_page_base     = r_page_base;
        n_within        = r_within;
        n_left          = r_left;
        n_evicted_valid = r_evicted_valid;
        n_evicted_base  = r_evicted_base;
        n_pin_count     = r_pin_count;
        page_we         = 1'b0;
        pins_we         = 1'b0;
        pins_waddr      = r_idx;
        pins_wdata      = r_pins;

        unique case (r_state)
            ppcl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_offset   = i_byte_offset;
                    n_rel_slot = i_release_slot;
                    n_state    = (i_req_type == ppcl_pkg::REQ_RELEASE) ?
                                 ppcl_pkg::S_REL_RD : ppcl_pkg::S_CHECK;
                end
            end

            // Range check and chunk length, then start the scan at the pointer.
            ppcl_pkg::S_CHECK: begin
                if (r_offset >= r_file_bytes) begin
                    n_fin   = ppcl_pkg::FIN_BEYOND;
                    n_state = ppcl_pkg::S_FIN;
                end else begin
                    n_len        = (span > OW'(ppcl_pkg::CHUNK_BYTES)) ?
                                   ppcl_pkg::CHUNK_BYTES : span[LW-1:0];
                    n_cur        = r_vp;
                    n_cnt        = '0;
                    n_hit        = 1'b0;
                    n_cand_found = 1'b0;
                    n_state      = ppcl_pkg::S_SCAN;
                end
            end

            // Released slot data has arrived from the memories.
            ppcl_pkg::S_REL_RD: begin
                n_idx   = IW'(r_rel_slot);
                n_vld   = r_valid[IW'(r_rel_slot)];
                n_pins  = r_valid[IW'(r_rel_slot)] ? rd_pins : '0;
                n_pg    = rd_page;
                n_fin   = (32'(r_rel_slot) >= 32'(POOL_ENTRIES)) ?
                          ppcl_pkg::FIN_REL_OOR : ppcl_pkg::FIN_REL;
                n_state = ppcl_pkg::S_FIN;
            end

            // One entry per cycle: tag compare and first free entry.
            ppcl_pkg::S_SCAN: begin
                n_cur = nxt_cur;
                n_cnt = r_cnt + IW'(1);
                if (scan_hit) begin
                    n_hit   = 1'b1;
                    n_idx   = r_cur;
                    n_pins  = rd_pins;
                    n_fin   = ppcl_pkg::FIN_ACQ;
                    n_state = ppcl_pkg::S_FIN;
                end else begin
                    if (!r_cand_found && scan_free) begin
                        n_cand_found = 1'b1;
                        n_cand       = r_cur;
                        n_ev_valid   = cur_valid;
                        n_ev_page    = rd_page;
                    end
                    if (r_cnt == LAST_IDX) begin
                        n_fin   = ppcl_pkg::FIN_ACQ;
                        n_state = ppcl_pkg::S_FIN;
                    end
                end
            end

            // Commit the state change and load the result register.
            ppcl_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_state         = ppcl_pkg::S_IDLE;
                    n_status        = ppcl_pkg::ST_HIT;
                    n_slot          = '0;
                    n_page_base     = '0;
                    n_within        = '0;
                    n_left          = '0;
                    n_evicted_valid = 1'b0;
                    n_evicted_base  = '0;
                    n_pin_count     = '0;
                    case (r_fin)
                        ppcl_pkg::FIN_BEYOND: begin
                            n_status = ppcl_pkg::ST_BEYOND;
                        end
                        ppcl_pkg::FIN_REL_OOR: begin
                            n_status = ppcl_pkg::ST_UNDERFLOW;
                            n_slot   = r_rel_slot;
                        end
                        ppcl_pkg::FIN_REL: begin
                            n_slot      = r_rel_slot;
                            n_page_base = r_vld ? {r_pg, {WW{1'b0}}} : '0;
                            if (r_pins == '0) begin
                                n_status = ppcl_pkg::ST_UNDERFLOW;
                            end else begin
                                pins_we     = 1'b1;
                                pins_wdata  = r_pins - NW'(1);
                                n_pin_count = r_pins - NW'(1);
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                pins_we     = 1'b1;
                                pins_wdata  = hit_pins;
                                n_slot      = SW'(r_idx);
                                n_page_base = req_base;
                                n_within    = req_within;
                                n_left      = r_len - LW'(req_within);
                                n_pin_count = hit_pins;
                            end else if (r_cand_found) begin
                                page_we         = 1'b1;
                                pins_we         = 1'b1;
                                pins_waddr      = r_cand;
                                pins_wdata      = NW'(1);
                                n_valid[r_cand] = 1'b1;
                                n_vp            = (r_cand == LAST_IDX) ?
                                                  '0 : r_cand + IW'(1);
                                n_status        = ppcl_pkg::ST_MISS;
                                n_slot          = SW'(r_cand);
                                n_page_base     = req_base;
                                n_within        = req_within;
                                n_left          = r_len - LW'(req_within);
                                n_evicted_valid = r_ev_valid;
                                n_evicted_base  = r_ev_valid ?
                                                  {r_ev_page, {WW{1'b0}}} : '0;
                                n_pin_count     = NW'(1);
                            end else begin
                                n_status = ppcl_pkg::ST_ALL_PINNED;
                                n_slot   = SW'(r_vp);
                            end
                        end
                    endcase
                end
            end

            default: begin
                n_state = ppcl_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ppcl_pkg::S_IDLE;
            r_valid      <= '0;
            r_vp         <= '0;
            r_out_valid  <= 1'b0;
            r_file_bytes <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_vp        <= n_vp;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_file_bytes <= i_cfg_file_bytes;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_fin           <= n_fin;
        r_offset        <= n_offset;
        r_rel_slot      <= n_rel_slot;
        r_len           <= n_len;
        r_cur           <= n_cur;
        r_cnt           <= n_cnt;
        r_hit           <= n_hit;
        r_idx           <= n_idx;
        r_pins          <= n_pins;
        r_pg            <= n_pg;
        r_vld           <= n_vld;
        r_cand_found    <= n_cand_found;
        r_cand          <= n_cand;
        r_ev_valid      <= n_ev_valid;
        r_ev_page       <= n_ev_page;
        r_status        <= n_status;
        r_slot          <= n_slot;
        r_page_base     <= n_page_base;
        r_within        <= n_within;
        r_left          <= n_left;
        r_evicted_valid <= n_evicted_valid;
        r_evicted_base  <= n_evicted_base;
        r_pin_count     <= n_pin_count;
    end

    // Port drivers.
    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != ppcl_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_page_base     = r_page_base;
    assign o_within_offset = r_within;
    assign o_bytes_left    = r_left;
    assign o_evicted_valid = r_evicted_valid;
    assign o_evicted_base  = r_evicted_base;
    assign o_pin_count     = r_pin_count;

    // Entries never become invalid once filled.
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid & ~n_valid) == '0))
        else $error("cache entry lost its valid bit");

    // The victim pointer moves only when a miss refills an entry.
    a_vp_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_vp != r_vp) |-> fill_go)
        else $error("victim pointer moved without a refill");

    // A new result appears only after the commit state.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ppcl_pkg::S_FIN))
        else $error("result raised outside the commit state");

    // The scan pointer stays inside the pool.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppcl_pkg::S_SCAN) |-> ((r_cur <= LAST_IDX) && (r_cnt <= LAST_IDX)))
        else $error("scan index beyond the pool");

    // Memories are written only while committing.
    a_write_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pins_we || page_we) |-> fin_go)
        else $error("memory write outside the commit state");

endmodule

`default_nettype wire

// File: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ppcl_pkg::*;

    localparam int unsigned POOL          = POOL_ENTRIES_DEF;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned QUIET_LIMIT   = 4000;

    // One request as it stands on the input channel.
    typedef struct packed {
        logic                kind;
        logic [OFF_W-1:0]    offset;
        logic [SLOT_W-1:0]   slot;
    } lookup_req_t;

    // One lookup result as it stands on the output channel.
    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [OFF_W-1:0]    page_base;
        logic [WITHIN_W-1:0] in_chunk;
        logic [LEFT_W-1:0]   left;
        logic                ev_valid;
        logic [OFF_W-1:0]    ev_base;
        logic [PIN_W-1:0]    pins;
    } lookup_result_t;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_valid      = 1'b0;
    logic [OFF_W-1:0]      i_cfg_file_bytes = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  i_out_stall      = 1'b0;
    lookup_req_t           cur_req          = '0;
    logic                  o_cfg_ready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [SLOT_W-1:0]     o_slot;
    logic [OFF_W-1:0]      o_page_base;
    logic [WITHIN_W-1:0]   o_within_offset;
    logic [LEFT_W-1:0]     o_bytes_left;
    logic                  o_evicted_valid;
    logic [OFF_W-1:0]      o_evicted_base;
    logic [PIN_W-1:0]      o_pin_count;

    // Shadow copy of the cache directory and the file size register.
    logic                  pred_valid [POOL];
    logic [PAGE_W-1:0]     pred_page  [POOL];
    logic [PIN_W-1:0]      pred_pins  [POOL];
    int unsigned           victim_ptr = 0;
    logic [OFF_W-1:0]      shadow_file_bytes = '0;

    lookup_req_t           pending_reqs [$];
    lookup_result_t        expected_results [$];
    logic                  req_fire     = 1'b0;
    int unsigned           idle_pct     = 0;
    int unsigned           stall_pct    = 0;
    int unsigned           n_issued     = 0;
    int unsigned           n_taken      = 0;
    int unsigned           n_errors     = 0;
    int unsigned           n_sizes      = 0;
    int unsigned           evict_seen   = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           status_seen [5] = '{default: 0};

    pinned_page_cache_lookup u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_file_bytes (i_cfg_file_bytes),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (cur_req.kind),
        .i_byte_offset    (cur_req.offset),
        .i_release_slot   (cur_req.slot),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_page_base      (o_page_base),
        .o_within_offset  (o_within_offset),
        .o_bytes_left     (o_bytes_left),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_base   (o_evicted_base),
        .o_pin_count      (o_pin_count)
    );

    always #2 i_clk = ~i_clk;

    // Applies one request to the shadow directory and returns the result it must give.
    function automatic lookup_result_t predict_lookup(lookup_req_t rq);
        lookup_result_t   res;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  base;
        logic [OFF_W-1:0]  span;
        int unsigned       idx;
        res = '0;
        if (rq.kind == REQ_RELEASE) begin
            idx = rq.slot;
            res.slot = rq.slot;
            res.page_base = pred_valid[idx] ? {pred_page[idx], WITHIN_W'(0)} : '0;
            if (pred_pins[idx] == '0) begin
                res.status = ST_UNDERFLOW;
                return res;
            end
            pred_pins[idx] = pred_pins[idx] - 1'b1;
            res.status = ST_HIT;
            res.pins = pred_pins[idx];
            return res;
        end
        if (rq.offset >= shadow_file_bytes) begin
            res.status = ST_BEYOND;
            return res;
        end
        page = rq.offset[OFF_W-1:WITHIN_W];
        base = {page, WITHIN_W'(0)};
        // The last chunk of the file can be shorter than a full chunk.
        span = shadow_file_bytes - base;
        if (span > OFF_W'(CHUNK_BYTES))
            span = OFF_W'(CHUNK_BYTES);
        res.page_base = base;
        res.in_chunk = rq.offset[WITHIN_W-1:0];
        res.left = LEFT_W'(span) - LEFT_W'(res.in_chunk);
        for (idx = 0; idx < POOL; idx++) begin
            if (pred_valid[idx] && pred_page[idx] == page) begin
                if (pred_pins[idx] != PIN_MAX)
                    pred_pins[idx] = pred_pins[idx] + 1'b1;
                res.status = ST_HIT;
                res.slot = SLOT_W'(idx);
                res.pins = pred_pins[idx];
                return res;
            end
        end
        // Miss: round-robin scan for an entry that is free or unpinned.
        for (int unsigned i = 0; i < POOL; i++) begin
            idx = (victim_ptr + i) % POOL;
            if (!pred_valid[idx] || pred_pins[idx] == '0) begin
                res.status = ST_MISS;
                res.slot = SLOT_W'(idx);
                res.ev_valid = pred_valid[idx];
                res.ev_base = pred_valid[idx] ? {pred_page[idx], WITHIN_W'(0)} : '0;
                res.pins = PIN_W'(1);
                pred_valid[idx] = 1'b1;
                pred_page[idx] = page;
                pred_pins[idx] = PIN_W'(1);
                victim_ptr = (idx + 1) % POOL;
                return res;
            end
        end
        res = '0;
        res.status = ST_ALL_PINNED;
        res.slot = SLOT_W'(victim_ptr);
        return res;
    endfunction

    // Draws one random request around a working set of pages.
    function automatic lookup_req_t random_request(logic [PAGE_W-1:0] ws_page,
                                                   int unsigned span);
        lookup_req_t      rq;
        int unsigned      pick;
        logic [OFF_W-1:0] tail;
        pick = $urandom_range(99);
        rq.kind = REQ_ACQUIRE;
        rq.offset = OFF_W'({$urandom(), $urandom()});
        rq.slot = SLOT_W'($urandom_range(POOL - 1));
        if (pick < 50) begin
            rq.offset = {ws_page + PAGE_W'($urandom_range(span - 1)),
                         WITHIN_W'($urandom_range(4095))};
        end else if (pick < 60 && shadow_file_bytes != '0) begin
            // Offsets close to the file end exercise the clipped length.
            tail = OFF_W'($urandom_range(4095));
            rq.offset = (tail < shadow_file_bytes) ? shadow_file_bytes - 1'b1 - tail : '0;
        end else if (pick >= 65) begin
            rq.kind = REQ_RELEASE;
        end
        return rq;
    endfunction

    task automatic push_req(input lookup_req_t rq);
        pending_reqs.push_back(rq);
        n_issued++;
    endtask

    task automatic acquire(input logic [OFF_W-1:0] offset);
        lookup_req_t rq;
        rq.kind = REQ_ACQUIRE;
        rq.offset = offset;
        rq.slot = SLOT_W'($urandom_range(POOL - 1));
        push_req(rq);
    endtask

    task automatic release_pin(input logic [SLOT_W-1:0] slot);
        lookup_req_t rq;
        rq.kind = REQ_RELEASE;
        rq.offset = OFF_W'({$urandom(), $urandom()});
        rq.slot = slot;
        push_req(rq);
    endtask

    // Waits until every request has been taken and every result has come back.
    task automatic wait_idle();
        while (n_taken != n_issued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_file_size(input logic [OFF_W-1:0] size);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_file_bytes <= size;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        shadow_file_bytes = size;
        n_sizes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [OFF_W-1:0] size, input logic [PAGE_W-1:0] ws,
                                input int unsigned span, input int unsigned count,
                                input int unsigned idle, input int unsigned stall);
        wait_idle();
        write_file_size(size);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count) push_req(random_request(ws, span));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Request driver: a new transfer is offered only once the previous one was taken.
    always @(negedge i_clk) begin
        if (!i_in_valid || req_fire) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_req <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Each accepted request is run through the shadow directory at once.
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(predict_lookup(cur_req));
            n_taken++;
        end
    end

    // Result monitor: every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        lookup_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_status <= ST_UNDERFLOW)
                status_seen[o_status]++;
            if (o_status == ST_MISS && o_evicted_valid)
                evict_seen++;
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with no request outstanding: status %0d, slot %0d",
                         $time, o_status, o_slot);
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("slot", want.slot, o_slot);
                check_field("page_base", want.page_base, o_page_base);
                check_field("within_offset", want.in_chunk, o_within_offset);
                check_field("bytes_left", want.left, o_bytes_left);
                check_field("evicted_valid", want.ev_valid, o_evicted_valid);
                check_field("evicted_base", want.ev_base, o_evicted_base);
                check_field("pin_count", want.pins, o_pin_count);
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still owed",
                     $time, QUIET_LIMIT, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [OFF_W-1:0]  rand_size;
        for (int i = 0; i < POOL; i++) begin
            pred_valid[i] = 1'b0;
            pred_page[i] = '0;
            pred_pins[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty file: every acquire lies beyond the end; release of a never-used slot.
        write_file_size('0);
        acquire('0);
        release_pin(SLOT_W'(3));

        // Short file with a partial last chunk: fill, hit, clipping, end bounds, underflow.
        wait_idle();
        write_file_size(OFF_W'(10000));
        acquire('0);
        acquire(OFF_W'(4095));
        acquire(OFF_W'(9999));
        acquire(OFF_W'(10000));
        acquire('1);
        release_pin(SLOT_W'(7));
        release_pin(SLOT_W'(0));
        release_pin(SLOT_W'(0));
        release_pin(SLOT_W'(0));

        // Largest file: fill every entry, evict an unpinned one, then find all pinned.
        wait_idle();
        write_file_size('1);
        acquire(OFF_W'(3 * 4096));
        acquire(40'hFF_FFFF_FFFE);
        acquire(40'h80_0000_0000);
        acquire(40'h55_5555_5555);
        acquire(40'hAA_AAAA_AAAA);
        acquire(40'h00_0000_1FFF);
        acquire(40'h12_3456_789A);
        acquire(40'h7F_FFFF_F000);
        acquire(40'hFF_FFFF_F000);

        // One-byte file: free one entry and fill it with the only byte.
        wait_idle();
        write_file_size(OFF_W'(1));
        release_pin(SLOT_W'(2));
        acquire('0);
        acquire(OFF_W'(1));

        // Random traffic under different file sizes and flow-control patterns.
        random_phase('1, PAGE_W'($urandom_range(32'h0FFF_FFF0)), 12, 240, 0, 0);
        random_phase(OFF_W'(5 * 4096 + 123), '0, 8, 240, 69, 0);
        random_phase(OFF_W'(12 * 4096), '0, 14, 240, 0, 69);
        rand_size = {8'($urandom_range(255)), 32'($urandom())};
        random_phase(rand_size, (rand_size[OFF_W-1:WITHIN_W] >= 6) ?
                     rand_size[OFF_W-1:WITHIN_W] - PAGE_W'(6) : '0, 12, 240, 7, 7);

        // Unpin everything, one release past zero per slot.
        wait_idle();
        idle_pct = 0;
        stall_pct = 0;
        for (int s = 0; s < POOL; s++)
            for (int j = 0; j <= int'(pred_pins[s]); j++)
                release_pin(SLOT_W'(s));
        wait_idle();

        $display("Run covered %0d requests under %0d file sizes and four flow-control patterns.",
                 n_taken, n_sizes);
        $display("Results: %0d hit/release, %0d fill (%0d evicting), %0d beyond end,",
                 status_seen[ST_HIT], status_seen[ST_MISS], evict_seen,
                 status_seen[ST_BEYOND]);
        $display("         %0d all pinned, %0d underflow.",
                 status_seen[ST_ALL_PINNED], status_seen[ST_UNDERFLOW]);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: pinned_page_cache_lookup.f
rtl/core/ppcl_pkg.sv
rtl/core/ppcl_ram.sv
rtl/core/pinned_page_cache_lookup.sv
verif/testbench.sv
